@@ sv/lcg_random_variate_generator_defines.svh @@
// ---------------------------------------------------------------------------
// lcg_random_variate_generator_defines.svh
// Assertion macros shared by the random variate generator RTL.
// ---------------------------------------------------------------------------
`ifndef LCG_RANDOM_VARIATE_GENERATOR_DEFINES_SVH
`define LCG_RANDOM_VARIATE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRVG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LRVG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lrvg_pkg.sv @@
// ---------------------------------------------------------------------------
// lrvg_pkg
// Types, widths, register indexes and helpers of the random variate generator.
// ---------------------------------------------------------------------------
`default_nettype none

package lrvg_pkg;

   localparam int SEED_W     = 20;
   localparam int REAL_W     = 32;
   localparam int COUNT_W    = 10;
   localparam int OPCODE_W   = 3;
   localparam int SIGMA_W    = 31;
   localparam int THRESH_W   = 21;
   localparam int TRIAL_W    = 10;
   localparam int LIMIT_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_MAX_COUNT = 1023;
   localparam int DEF_SUM_TERMS = 12;

   // shared multiplier: 18 x 25 signed, wide operand taken in two 17-bit halves
   localparam int OPND_W     = 34;
   localparam int HALF_W     = 17;
   localparam int MUL_A_W    = HALF_W + 1;
   localparam int MUL_B_W    = 25;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 64;
   localparam int FRAC_SHIFT = 20;
   localparam int TOTAL_W    = ACC_W - FRAC_SHIFT + 1;
   localparam int PROD_B_W   = 33;

   // reset values of the control registers
   localparam logic [REAL_W-1:0]   RST_UNIFORM_LOW  = 32'sd0;
   localparam logic [REAL_W-1:0]   RST_UNIFORM_HIGH = 32'sd65536;
   localparam logic [REAL_W-1:0]   RST_GAUSS_MEAN   = 32'sd0;
   localparam logic [SIGMA_W-1:0]  RST_GAUSS_SIGMA  = 31'd65536;
   localparam logic [THRESH_W-1:0] RST_THRESHOLD    = 21'd524288;
   localparam logic [TRIAL_W-1:0]  RST_TRIAL_COUNT  = 10'd1;
   localparam logic [LIMIT_W-1:0]  RST_POISSON_LIM  = 32'd1580030169;
   localparam logic [SEED_W-1:0]   RST_SEED         = 20'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_MEAN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_SIGMA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIAL_COUNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_POISSON_LIM  = 3'd6;

   typedef enum logic [OPCODE_W-1:0] {
      OP_UNIFORM   = 3'd0,
      OP_GAUSSIAN  = 3'd1,
      OP_BERNOULLI = 3'd2,
      OP_BINOMIAL  = 3'd3,
      OP_POISSON   = 3'd4,
      OP_RESEED    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PCHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                draw;
      logic                mul_lo;
      logic                mul_hi;
      logic                pcheck;
      logic                emit;
   } ctrl_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SEED_W-1:0]   seed_value;
   } req_type;

   typedef struct packed {
      logic signed [REAL_W-1:0] real_value;
      logic [COUNT_W-1:0]       count_value;
      logic                     clipped;
   } rsp_type;

   // seed * 2045 + 1 mod 2^20, with 2045 = 2048 - 2 - 1
   function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] x11;
      logic [SEED_W-1:0] x2;
      x11 = {s[SEED_W-12:0], 11'b0};
      x2  = {s[SEED_W-2:0], 1'b0};
      return x11 - x2 - s + {{(SEED_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

@@ sv/lcg_random_variate_generator.sv @@
// ---------------------------------------------------------------------------
// lcg_random_variate_generator
// LCG-driven generator of uniform, Gaussian, Bernoulli, binomial and Poisson
// variates, one result transaction per request transaction.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_stall  | req_data  (opcode, seed_value)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (real, count, clipped)
//   csr     | in        | csr_we, csr_index    | csr_wdata (write only)
//
// From accept: uniform DRAW, MUL_LO, MUL_HI; Gaussian one DRAW per summed term,
// MUL_LO, MUL_HI; Bernoulli one DRAW; binomial one DRAW per trial; Poisson DRAW,
// MUL_LO, MUL_HI, PCHECK per uniform until below the limit or at MAX_COUNT;
// then FINISH loads the result register, waiting while the previous result is
// held. Reseed, unused opcodes and zero trials go straight to FINISH. Each DRAW
// is one seed step; the one 18x25 multiplier takes two passes per wide product.
// One request at a time: req_stall is high from accept until the result is
// moved into the output register. Reset is synchronous; no clearing pass.
// A stalled result sits in the output register while the next request runs.
//
`default_nettype none

`include "lcg_random_variate_generator_defines.svh"

module lcg_random_variate_generator
   import lrvg_pkg::*;
#(
   parameter int MAX_COUNT = DEF_MAX_COUNT,
   parameter int SUM_TERMS = DEF_SUM_TERMS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_data,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_data,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // count register must hold the binomial count and the Poisson cap
   localparam int CAP_W = $clog2(MAX_COUNT + 1);
   localparam int CNT_W = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;
   // Gaussian sum starts at -SUM_TERMS/2 in Q.20
   localparam logic signed [MUL_B_W-1:0] SUM_INIT =
      MUL_B_W'(-(SUM_TERMS * (1 << (SEED_W - 1))));
   localparam logic [TRIAL_W-1:0] GAUSS_DRAWS = TRIAL_W'(SUM_TERMS);
   localparam logic [CNT_W-1:0]   COUNT_CAP   = CNT_W'(MAX_COUNT);

   // ---------------- control registers ----------------
   logic signed [REAL_W-1:0]   uniform_low_ff;
   logic signed [REAL_W-1:0]   uniform_high_ff;
   logic signed [REAL_W-1:0]   gauss_mean_ff;
   logic [SIGMA_W-1:0]         gauss_sigma_ff;
   logic [THRESH_W-1:0]        threshold_ff;
   logic [TRIAL_W-1:0]         trial_count_ff;
   logic [LIMIT_W-1:0]         poisson_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uniform_low_ff  <= RST_UNIFORM_LOW;
         uniform_high_ff <= RST_UNIFORM_HIGH;
         gauss_mean_ff   <= RST_GAUSS_MEAN;
         gauss_sigma_ff  <= RST_GAUSS_SIGMA;
         threshold_ff    <= RST_THRESHOLD;
         trial_count_ff  <= RST_TRIAL_COUNT;
         poisson_lim_ff  <= RST_POISSON_LIM;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UNIFORM_LOW:  uniform_low_ff  <= csr_wdata;
            CSR_UNIFORM_HIGH: uniform_high_ff <= csr_wdata;
            CSR_GAUSS_MEAN:   gauss_mean_ff   <= csr_wdata;
            CSR_GAUSS_SIGMA:  gauss_sigma_ff  <= csr_wdata[SIGMA_W-1:0];
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata[THRESH_W-1:0];
            CSR_TRIAL_COUNT:  trial_count_ff  <= csr_wdata[TRIAL_W-1:0];
            CSR_POISSON_LIM:  poisson_lim_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;  // index past the list: ignored
         endcase
      end
   end

   // ---------------- sequencer and datapath state ----------------
   state_type                  state_ff, state_in;
   ctrl_type                   ctrl;
   op_type                     op_ff, op_in;
   logic [SEED_W-1:0]          seed_ff, seed_in;
   logic [TRIAL_W-1:0]         iter_ff, iter_in;
   logic signed [MUL_B_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       clip_ff, clip_in;
   logic [OPND_W-1:0]          opnd_ff, opnd_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   rsp_type                    rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       accept;
   op_type                     req_op;
   logic                       out_free;
   logic [SEED_W-1:0]          seed_step;
   logic [TRIAL_W-1:0]         iter_inc;
   logic [TRIAL_W-1:0]         draw_target;
   logic                       last_draw;
   logic                       success;
   logic [CNT_W-1:0]           count_inc;
   logic [PROD_B_W-1:0]        prod_b;
   logic                       below_limit;
   logic                       at_cap;
   logic signed [PROD_B_W-1:0] uni_diff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_p;
   logic signed [REAL_W-1:0]   base;
   logic signed [TOTAL_W-1:0]  total;
   logic                       ovf;
   logic signed [REAL_W-1:0]   real_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_op    = op_type'(req_data.opcode);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one seed step per draw
   assign seed_step = lcg_next(seed_ff);
   assign iter_inc  = iter_ff + 1'b1;
   assign success   = {1'b0, seed_step} < threshold_ff;
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      case (op_ff) inside
         OP_GAUSSIAN: draw_target = GAUSS_DRAWS;
         OP_BINOMIAL: draw_target = trial_count_ff;
         default:     draw_target = TRIAL_W'(1);
      endcase
   end
   assign last_draw = (iter_inc == draw_target);

   // Poisson product after the two multiply passes: floor(b*u / 2^20)
   assign prod_b      = acc_ff[FRAC_SHIFT+PROD_B_W-1:FRAC_SHIFT];
   assign below_limit = prod_b < {1'b0, poisson_lim_ff};
   assign at_cap      = (count_inc == COUNT_CAP);

   // shared multiplier: low half of the wide operand first, then the high half
   assign mul_a = ctrl.mul_hi ? MUL_A_W'(signed'({opnd_ff[OPND_W-1], opnd_ff[OPND_W-1:HALF_W]}))
                              : MUL_A_W'(signed'({1'b0, opnd_ff[HALF_W-1:0]}));
   assign mul_b = (op_ff == OP_GAUSSIAN) ? sum_ff
                                         : signed'({{(MUL_B_W-SEED_W){1'b0}}, seed_ff});
   assign mul_p = mul_a * mul_b;

   assign uni_diff = {uniform_high_ff[REAL_W-1], uniform_high_ff}
                   - {uniform_low_ff[REAL_W-1], uniform_low_ff};

   // final scale: base + floor(acc / 2^20), saturated to 32 bits
   assign base  = (op_ff == OP_GAUSSIAN) ? gauss_mean_ff : uniform_low_ff;
   assign total = {acc_ff[ACC_W-1], acc_ff[ACC_W-1:FRAC_SHIFT]}
                + {{(TOTAL_W-REAL_W){base[REAL_W-1]}}, base};
   assign ovf   = (total[TOTAL_W-1:REAL_W-1] != {(TOTAL_W-REAL_W+1){total[TOTAL_W-1]}});
   assign real_sat = total[TOTAL_W-1] ? {1'b1, {(REAL_W-1){1'b0}}}
                                      : {1'b0, {(REAL_W-1){1'b1}}};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_UNIFORM, OP_GAUSSIAN, OP_BERNOULLI, OP_POISSON: state_in = ST_DRAW;
                  OP_BINOMIAL:
                     state_in = (trial_count_ff == '0) ? ST_FINISH : ST_DRAW;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_DRAW: begin
            case (op_ff) inside
               OP_UNIFORM, OP_POISSON: state_in = ST_MUL_LO;
               OP_GAUSSIAN:            state_in = last_draw ? ST_MUL_LO : ST_DRAW;
               default:                state_in = last_draw ? ST_FINISH : ST_DRAW;
            endcase
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = (op_ff == OP_POISSON) ? ST_PCHECK : ST_FINISH;
         ST_PCHECK: state_in = (below_limit || at_cap) ? ST_FINISH : ST_DRAW;
         ST_FINISH: state_in = out_free ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:   ;
         ST_DRAW:   ctrl.draw   = 1'b1;
         ST_MUL_LO: ctrl.mul_lo = 1'b1;
         ST_MUL_HI: ctrl.mul_hi = 1'b1;
         ST_PCHECK: ctrl.pcheck = 1'b1;
         ST_FINISH: ctrl.emit   = out_free;
         default:   ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in        = accept ? req_op : op_ff;

      seed_in      = seed_ff;
      if (accept && (req_op == OP_RESEED)) begin
         seed_in = req_data.seed_value;
      end else if (ctrl.draw) begin
         seed_in = seed_step;
      end

      iter_in      = accept ? '0 : (ctrl.draw ? iter_inc : iter_ff);

      sum_in       = sum_ff;
      if (accept) begin
         sum_in = SUM_INIT;
      end else if (ctrl.draw) begin
         sum_in = sum_ff + signed'({{(MUL_B_W-SEED_W){1'b0}}, seed_step});
      end

      count_in     = count_ff;
      clip_in      = clip_ff;
      if (accept) begin
         count_in = '0;
         clip_in  = 1'b0;
      end else if (ctrl.draw && success &&
                   (op_ff == OP_BERNOULLI || op_ff == OP_BINOMIAL)) begin
         count_in = count_inc;
      end else if (ctrl.pcheck && !below_limit) begin
         count_in = count_inc;
         clip_in  = at_cap;
      end

      opnd_in      = opnd_ff;
      if (accept) begin
         case (req_op) inside
            OP_UNIFORM:  opnd_in = {uni_diff[PROD_B_W-1], uni_diff};
            OP_GAUSSIAN: opnd_in = {{(OPND_W-SIGMA_W){1'b0}}, gauss_sigma_ff};
            OP_POISSON:  opnd_in = OPND_W'(1) << LIMIT_W;   // product starts at 1.0
            default:     opnd_in = opnd_ff;
         endcase
      end else if (ctrl.pcheck) begin
         opnd_in = {1'b0, prod_b};
      end

      acc_in       = acc_ff;
      if (ctrl.mul_lo) begin
         acc_in = {{(ACC_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
      end else if (ctrl.mul_hi) begin
         acc_in = acc_ff + {{(ACC_W-MUL_P_W-HALF_W){mul_p[MUL_P_W-1]}}, mul_p,
                            {HALF_W{1'b0}}};
      end

      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit) begin
         rsp_data_in = '0;
         case (op_ff) inside
            OP_UNIFORM, OP_GAUSSIAN: begin
               rsp_data_in.real_value = ovf ? real_sat : total[REAL_W-1:0];
               rsp_data_in.clipped    = ovf;
            end
            OP_BERNOULLI, OP_BINOMIAL, OP_POISSON: begin
               rsp_data_in.count_value = count_ff[COUNT_W-1:0];
               rsp_data_in.clipped     = clip_ff;
            end
            default: ;  // reseed and unused codes: all zero
         endcase
      end

      rsp_valid_in = ctrl.emit || (rsp_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= RST_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      iter_ff     <= iter_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      clip_ff     <= clip_in;
      opnd_ff     <= opnd_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   `LRVG_ASSERT_NXT(a_reseed_loads, clock, reset, accept && (req_op == OP_RESEED), seed_ff == $past(req_data.seed_value), "reseed did not load the seed")
   `LRVG_ASSERT_IMP(a_pois_prod_range, clock, reset, state_ff == ST_PCHECK, acc_ff[ACC_W-1:FRAC_SHIFT+PROD_B_W-1] == '0, "poisson product out of range")
   `LRVG_ASSERT_IMP(a_pois_below_cap, clock, reset, state_ff == ST_PCHECK, count_ff < COUNT_CAP, "poisson count past cap while iterating")
   `LRVG_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "result raised outside finish")

endmodule

`default_nettype wire
